// ===== sv/tks_pkg.sv =====
// Shared types and constants for the top-k sum block.
`timescale 1ns / 1ps

package tks_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 42;
    localparam int POS_W    = 32;
    localparam int PEN_W    = 31;
    localparam int SLOT_W   = 11;
    localparam int PROD_W   = PEN_W + POS_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam int OUT_DATA_W = 88;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_RATE = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ROOT,
        ST_UP,
        ST_DOWN,
        ST_PLACE,
        ST_SCORE
    } state_t;

    typedef struct packed {
        logic load;
        logic append;
        logic read_root;
        logic replace;
        logic up_step;
        logic down_step;
        logic place;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic positive;
        logic limit_zero;
        logic room;
        logic count_zero;
        logic one_entry;
        logic take_root;
        logic up_move;
        logic parent_zero;
        logic down_move;
        logic down_more;
        logic out_free;
    } status_t;

endpackage

// ===== sv/tks_ram.sv =====
// Generic memory with one write port and two registered read ports.
`timescale 1ns / 1ps

module tks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== sv/tks_ctrl.sv =====
// Sequencer for heap insert, root replacement and score update.
`timescale 1ns / 1ps

module tks_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tks_pkg::status_t status,
    output tks_pkg::cmd_t    cmd
);

    tks_pkg::state_t state_reg;
    tks_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tks_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            tks_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tks_pkg::ST_DECIDE;
                end
            end
            tks_pkg::ST_DECIDE:
            begin
                if (!status.positive || status.limit_zero)
                begin
                    state_next = tks_pkg::ST_SCORE;
                end
                else if (status.room)
                begin
                    cmd.append = 1'b1;
                    state_next = status.count_zero ? tks_pkg::ST_PLACE : tks_pkg::ST_UP;
                end
                else
                begin
                    cmd.read_root = 1'b1;
                    state_next    = tks_pkg::ST_ROOT;
                end
            end
            tks_pkg::ST_ROOT:
            begin
                if (status.take_root)
                begin
                    cmd.replace = 1'b1;
                    state_next  = status.one_entry ? tks_pkg::ST_PLACE : tks_pkg::ST_DOWN;
                end
                else
                begin
                    state_next = tks_pkg::ST_SCORE;
                end
            end
            tks_pkg::ST_UP:
            begin
                if (status.up_move)
                begin
                    cmd.up_step = 1'b1;
                    if (status.parent_zero)
                    begin
                        state_next = tks_pkg::ST_PLACE;
                    end
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = tks_pkg::ST_SCORE;
                end
            end
            tks_pkg::ST_DOWN:
            begin
                if (status.down_move)
                begin
                    cmd.down_step = 1'b1;
                    if (!status.down_more)
                    begin
                        state_next = tks_pkg::ST_PLACE;
                    end
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = tks_pkg::ST_SCORE;
                end
            end
            tks_pkg::ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = tks_pkg::ST_SCORE;
            end
            tks_pkg::ST_SCORE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = tks_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tks_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == tks_pkg::ST_DECIDE)
        else $error("transaction accepted without entering decide");

    a_score_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tks_pkg::ST_SCORE && !status.out_free |=> state_reg == tks_pkg::ST_SCORE)
        else $error("result dropped while output busy");

    a_one_heap_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.append, cmd.replace, cmd.up_step, cmd.down_step, cmd.place}))
        else $error("conflicting heap commands");
`endif

endmodule

// ===== sv/tks_dp.sv =====
// Datapath: heap memory, sum, position, score and result register.
`timescale 1ns / 1ps

module tks_dp #(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tks_pkg::cmd_t                     cmd,
    output tks_pkg::status_t                  status,
    input  logic [tks_pkg::SAMPLE_W-1:0]      sample_in,
    input  logic                              begin_in,
    input  logic                              cfg_we,
    input  logic [tks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tks_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tks_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);

    localparam int AW   = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW   = $clog2(HEAP_DEPTH + 1);
    localparam int KW   = AW + 2;
    localparam int SW   = tks_pkg::SUM_W;
    localparam int DW   = tks_pkg::SAMPLE_W;
    localparam int PW   = tks_pkg::PROD_W;
    localparam int PADW = tks_pkg::OUT_DATA_W - 2 * SW;

    logic [DW-1:0]               sample_reg;
    logic [CW-1:0]               count_reg;
    logic [SW-1:0]               sum_reg;
    logic [SW-1:0]               best_reg;
    logic [tks_pkg::POS_W-1:0]   pos_reg;
    logic [PW-1:0]               prod_reg;
    logic [AW-1:0]               hole_reg;
    logic                        acc_reg;
    logic [tks_pkg::SLOT_W-1:0]  slot_reg;
    logic [tks_pkg::PEN_W-1:0]   pen_reg;
    logic                        out_valid_reg;
    logic [SW-1:0]               out_sum_reg;
    logic [SW-1:0]               out_best_reg;
    logic                        out_acc_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DW-1:0]     wr_data;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic [DW-1:0]     rd_data_a;
    logic [DW-1:0]     rd_data_b;

    logic [AW-1:0]     cnt_parent;
    logic [AW-1:0]     hole_parent;
    logic [AW-1:0]     hole_grand;
    logic [KW-1:0]     count_k;
    logic [KW-1:0]     child_l;
    logic [KW-1:0]     child_r;
    logic              pick_right;
    logic [KW-1:0]     pick_k;
    logic [AW-1:0]     pick_h;
    logic [DW-1:0]     pick_val;
    logic [KW-1:0]     pick_l;
    logic [KW-1:0]     pick_r;
    logic              out_free;
    logic              score_ok;
    logic [SW-1:0]     score;
    logic [SW-1:0]     best_next;

    tks_ram #(
        .WIDTH (DW),
        .DEPTH (HEAP_DEPTH)
    ) u_heap (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign cnt_parent  = (count_reg[AW-1:0] - AW'(1)) >> 1;
    assign hole_parent = (hole_reg - AW'(1)) >> 1;
    assign hole_grand  = (hole_parent - AW'(1)) >> 1;
    assign count_k     = KW'(count_reg);
    assign child_l     = {1'b0, hole_reg, 1'b1};
    assign child_r     = child_l + KW'(1);
    assign pick_right  = (child_r < count_k) && (rd_data_b < rd_data_a);
    assign pick_k      = pick_right ? child_r : child_l;
    assign pick_val    = pick_right ? rd_data_b : rd_data_a;
    assign pick_h      = pick_k[AW-1:0];
    assign pick_l      = {1'b0, pick_h, 1'b1};
    assign pick_r      = pick_l + KW'(1);
    assign out_free    = !out_valid_reg || m_tready;

    assign score_ok  = prod_reg <= PW'(sum_reg);
    assign score     = sum_reg - prod_reg[SW-1:0];
    assign best_next = (acc_reg && score_ok && score > best_reg) ? score : best_reg;

    always_comb
    begin
        status.positive    = (sample_reg != '0) && !sample_reg[DW-1];
        status.limit_zero  = (slot_reg == '0);
        status.room        = (32'(count_reg) < 32'(slot_reg)) && (32'(count_reg) < HEAP_DEPTH);
        status.count_zero  = (count_reg == '0);
        status.one_entry   = (count_reg == CW'(1));
        status.take_root   = sample_reg >= rd_data_a;
        status.up_move     = sample_reg < rd_data_a;
        status.parent_zero = (hole_parent == '0);
        status.down_move   = pick_val < sample_reg;
        status.down_more   = pick_l < count_k;
        status.out_free    = out_free;
    end

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = hole_reg;
        wr_data   = sample_reg;
        rd_addr_a = '0;
        rd_addr_b = '0;
        if (cmd.append)
        begin
            rd_addr_a = cnt_parent;
        end
        if (cmd.read_root)
        begin
            rd_addr_a = '0;
        end
        if (cmd.replace)
        begin
            rd_addr_a = AW'(1);
            rd_addr_b = AW'(2);
        end
        if (cmd.up_step)
        begin
            wr_en     = 1'b1;
            wr_data   = rd_data_a;
            rd_addr_a = hole_grand;
        end
        if (cmd.down_step)
        begin
            wr_en     = 1'b1;
            wr_data   = pick_val;
            rd_addr_a = pick_l[AW-1:0];
            rd_addr_b = pick_r[AW-1:0];
        end
        if (cmd.place)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            pos_reg       <= '0;
            acc_reg       <= 1'b0;
            slot_reg      <= tks_pkg::SLOT_W'(1);
            pen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tks_pkg::CFG_SLOT_LIMIT:   slot_reg <= cfg_data[tks_pkg::SLOT_W-1:0];
                    tks_pkg::CFG_PENALTY_RATE: pen_reg  <= cfg_data[tks_pkg::PEN_W-1:0];
                    default:                   slot_reg <= slot_reg;
                endcase
            end
            if (cmd.load)
            begin
                acc_reg <= 1'b0;
                if (begin_in)
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    best_reg  <= '0;
                    pos_reg   <= tks_pkg::POS_W'(1);
                end
                else if (pos_reg != '1)
                begin
                    pos_reg <= pos_reg + tks_pkg::POS_W'(1);
                end
            end
            if (cmd.append)
            begin
                acc_reg   <= 1'b1;
                count_reg <= count_reg + CW'(1);
                sum_reg   <= sum_reg + SW'(sample_reg);
            end
            if (cmd.replace)
            begin
                acc_reg <= 1'b1;
                sum_reg <= sum_reg + SW'(sample_reg) - SW'(rd_data_a);
            end
            if (cmd.finish)
            begin
                best_reg      <= best_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(pen_reg) * PW'(pos_reg);
        if (cmd.load)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.append)
        begin
            hole_reg <= count_reg[AW-1:0];
        end
        if (cmd.replace)
        begin
            hole_reg <= '0;
        end
        if (cmd.up_step)
        begin
            hole_reg <= hole_parent;
        end
        if (cmd.down_step)
        begin
            hole_reg <= pick_h;
        end
        if (cmd.finish)
        begin
            out_sum_reg  <= sum_reg;
            out_best_reg <= best_next;
            out_acc_reg  <= acc_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_acc_reg;
    assign m_tdata  = {{PADW{1'b0}}, out_best_reg, out_sum_reg};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= HEAP_DEPTH)
        else $error("heap count beyond depth");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg && out_sum_reg == $past(sum_reg))
        else $error("result register not loaded");
`endif

endmodule

// ===== sv/top_k_sum_with_position_penalty.sv =====
// Top level of the streaming top-k sum with position penalty.
`timescale 1ns / 1ps

// Keeps the sum of the largest positive samples of a set in a min-heap of
// up to slot_limit entries and reports, per sample, whether it was taken,
// the kept sum and the best penalized score so far. One sample is handled
// at a time: a dropped sample goes from the decision straight to scoring,
// a sample rejected against the heap minimum first reads the root, an
// inserted one climbs one heap level per step, and a root replacement
// sinks one level per step before the sample is placed and scored; a
// result held by the receiver stalls the next sample. Each heap level
// costs one step of the single heap memory (registered read, compare,
// write). The heap memory needs no clearing after reset. Configuration
// writes are taken on any cycle and must only be issued while the block is
// idle.
module top_k_sum_with_position_penalty #(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] sample_value
    input  logic                              s_tuser,   // [0] begin_set
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tks_pkg::OUT_DATA_W-1:0]    m_tdata,   // [41:0] kept_sum, [83:42] best_score
    output logic                              m_tuser,   // [0] accepted
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tks_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tks_pkg::cmd_t    cmd;
    tks_pkg::status_t status;

    assign cfg_ready = 1'b1;

    tks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tks_dp #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample_in (s_tdata),
        .begin_in  (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
